[rtl/core/bole_pkg.sv]
// Shared types and codes for the bounded ordered list engine.
package bole_pkg;

   typedef enum logic [2:0] {
      KIND_PUSH_FRONT = 3'd0,
      KIND_PUSH_BACK  = 3'd1,
      KIND_INSERT     = 3'd2,
      KIND_POP_FRONT  = 3'd3,
      KIND_POP_BACK   = 3'd4,
      KIND_REMOVE     = 3'd5,
      KIND_MODIFY     = 3'd6,
      KIND_SEARCH     = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      ST_DONE   = 2'd0,
      ST_BADPOS = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   localparam int POS_WIDTH   = 5;
   localparam int COUNT_WIDTH = 5;
   localparam int DATA_WIDTH  = 32;

   // Broadcast command from the controller to every cell; at most one bit set.
   typedef struct packed {
      logic open_gap;   // insert: shift right from position, write key there
      logic close_gap;  // remove: shift left from position
      logic overwrite;  // modify: write key at position
      logic search;     // compare occupied cells against key
   } cell_ctl_type;

endpackage

[rtl/core/bole_cell.sv]
// One list slot: holds an entry, shifts with its neighbors, compares for search.
module bole_cell #(
   parameter int SW    = 32,
   parameter int IW    = 4,
   parameter int CW    = 5,
   parameter int INDEX = 0
) (
   input  logic                  clock,
   input  bole_pkg::cell_ctl_type ctl,
   input  logic [IW-1:0]         pos,
   input  logic [CW-1:0]         count,
   input  logic [SW-1:0]         key,
   input  logic [SW-1:0]         left_data,
   input  logic [SW-1:0]         right_data,
   output logic [SW-1:0]         data,
   output logic                  match
);
   import bole_pkg::*;

   localparam logic [IW-1:0] MY_POS = IW'(INDEX);
   localparam logic [CW-1:0] MY_CNT = CW'(INDEX);

   logic [SW-1:0] data_ff;
   logic [SW-1:0] data_in;
   logic          match_ff;
   logic          match_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.open_gap) begin
         if (MY_POS > pos) begin
            data_in = left_data;
         end else if (MY_POS == pos) begin
            data_in = key;
         end
      end else if (ctl.close_gap) begin
         if (MY_POS >= pos) begin
            data_in = right_data;
         end
      end else if (ctl.overwrite && (MY_POS == pos)) begin
         data_in = key;
      end
   end

   // only slots below the count hold live entries
   assign match_in = (MY_CNT < count) && (data_ff == key);

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (ctl.search) begin
         match_ff <= match_in;
      end
   end

   assign data  = data_ff;
   assign match = match_ff;

endmodule

[rtl/core/bounded_ordered_list_engine_unit.sv]
// Top level of the bounded ordered list engine: command decode, cell row, result register.
//
//  channel | direction | ports                                     | handshake
//  req     | in        | req_kind, req_position, req_value         | req_valid / req_stall
//  rsp     | out       | rsp_status, rsp_found, rsp_count          | rsp_valid / rsp_stall
//
// One request per cycle while req_stall is low; every op is a single parallel step of the
// cell row. The cells update and register search hits, then the hit OR and status land
// in the result register.
// Reset clears the count and pipeline valids; entries are left as they are.
// A stalled result holds one request in the middle stage, then req_stall rises.
module bounded_ordered_list_engine_unit #(
   parameter int CAPACITY    = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [4:0]  req_position,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_found,
   output logic [4:0]  rsp_count
);
   import bole_pkg::*;

   localparam int SW = (VALUE_WIDTH < DATA_WIDTH) ? VALUE_WIDTH : DATA_WIDTH;
   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > POS_WIDTH) ? CW : POS_WIDTH;
   localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   logic          mid_valid_ff;
   logic          mid_valid_in;
   status_type    mid_status_ff;
   logic [4:0]    mid_count_ff;
   logic          mid_search_ff;

   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   status_type    rsp_status_ff;
   logic          rsp_found_ff;
   logic [4:0]    rsp_count_ff;

   logic          accept;
   logic          out_free;
   logic          mid_advance;

   logic          full;
   logic          empty;
   logic [PW-1:0] pos_x;
   logic [PW-1:0] count_x;
   logic [PW-1:0] eff_pos;
   logic          ins_ok;
   logic          rem_ok;
   logic          mod_ok;
   logic          is_search;
   status_type    status;

   cell_ctl_type  ctl;
   logic [SW-1:0] key;
   logic [SW-1:0] cell_data [CAPACITY];
   logic [CAPACITY-1:0] hits;

   function automatic logic [4:0] count_x_next(input logic [CW-1:0] c);
      logic [PW-1:0] wide;
      wide = PW'(c);
      return wide[COUNT_WIDTH-1:0];
   endfunction

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign mid_advance = mid_valid_ff && out_free;
   assign req_stall   = mid_valid_ff && !out_free;
   assign accept      = req_valid && !req_stall;

   assign full    = (count_ff == CAP_CNT);
   assign empty   = (count_ff == '0);
   assign pos_x   = PW'(req_position);
   assign count_x = PW'(count_ff);
   assign key     = req_value[SW-1:0];

   always_comb begin
      ins_ok    = 1'b0;
      rem_ok    = 1'b0;
      mod_ok    = 1'b0;
      is_search = 1'b0;
      status    = ST_DONE;
      eff_pos   = pos_x;
      case (kind_type'(req_kind))
         KIND_PUSH_FRONT, KIND_PUSH_BACK, KIND_INSERT: begin
            if (kind_type'(req_kind) == KIND_PUSH_FRONT) begin
               eff_pos = '0;
            end else if (kind_type'(req_kind) == KIND_PUSH_BACK) begin
               eff_pos = count_x;
            end
            if (full) begin
               status = ST_FULL;
            end else if (kind_type'(req_kind) == KIND_INSERT && pos_x > count_x) begin
               status = ST_BADPOS;
            end else begin
               ins_ok = 1'b1;
            end
         end
         KIND_POP_FRONT, KIND_POP_BACK, KIND_REMOVE: begin
            if (kind_type'(req_kind) == KIND_POP_FRONT) begin
               eff_pos = '0;
            end else if (kind_type'(req_kind) == KIND_POP_BACK) begin
               eff_pos = count_x - PW'(1);
            end
            if (empty) begin
               status = ST_EMPTY;
            end else if (kind_type'(req_kind) == KIND_REMOVE && pos_x >= count_x) begin
               status = ST_BADPOS;
            end else begin
               rem_ok = 1'b1;
            end
         end
         KIND_MODIFY: begin
            if (empty) begin
               status = ST_EMPTY;
            end else if (pos_x >= count_x) begin
               status = ST_BADPOS;
            end else begin
               mod_ok = 1'b1;
            end
         end
         default: begin
            is_search = 1'b1;
         end
      endcase
   end

   assign ctl.open_gap  = accept && ins_ok;
   assign ctl.close_gap = accept && rem_ok;
   assign ctl.overwrite = accept && mod_ok;
   assign ctl.search    = accept && is_search;

   always_comb begin
      count_in = count_ff;
      if (ctl.open_gap) begin
         count_in = count_ff + CW'(1);
      end else if (ctl.close_gap) begin
         count_in = count_ff - CW'(1);
      end
   end

   // cell row: left neighbor feeds inserts, right neighbor feeds removes
   for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [SW-1:0] left_data;
      logic [SW-1:0] right_data;
      if (gi == 0) begin : g_first
         assign left_data = key;
      end else begin : g_left
         assign left_data = cell_data[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
         assign right_data = cell_data[gi];
      end else begin : g_right
         assign right_data = cell_data[gi+1];
      end
      bole_cell #(
         .SW    (SW),
         .IW    (IW),
         .CW    (CW),
         .INDEX (gi)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .pos        (eff_pos[IW-1:0]),
         .count      (count_ff),
         .key        (key),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[gi]),
         .match      (hits[gi])
      );
   end

   assign mid_valid_in = accept || (mid_valid_ff && !out_free);
   assign rsp_valid_in = mid_advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         mid_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         mid_valid_ff <= mid_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mid_status_ff <= status;
         mid_count_ff  <= count_x_next(count_in);
         mid_search_ff <= is_search;
      end
   end

   always_ff @(posedge clock) begin
      if (mid_advance) begin
         rsp_status_ff <= mid_status_ff;
         rsp_found_ff  <= mid_search_ff && (|hits);
         rsp_count_ff  <= mid_count_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_count  = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("entry count above capacity");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_status == ST_DONE)
      else $error("found flag with error status");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      ctl.open_gap |=> count_ff == $past(count_ff) + CW'(1))
      else $error("accepted insert did not grow count");

   a_error_holds: assert property (@(posedge clock) disable iff (reset)
      accept && status != ST_DONE |=> count_ff == $past(count_ff))
      else $error("failed request changed count");

endmodule
